// File: rtl/bblru_pkg.sv
// shared types, codes and defaults for the byte budget lru cache directory
package bblru_pkg;

    localparam int SLOTS_DEF    = 64;
    localparam int PIN_BITS_DEF = 8;
    localparam int KEY_W        = 52;

    localparam logic [1:0] KIND_ACQUIRE = 2'd0;
    localparam logic [1:0] KIND_PEEK    = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;
    localparam logic [1:0] KIND_SWEEP   = 2'd3;

    localparam logic [2:0] ST_HIT       = 3'd0;
    localparam logic [2:0] ST_INSERTED  = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_LOAD_FAIL = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_LOOK,
        S_REL1,
        S_REL2,
        S_SW_CHK,
        S_VSCAN,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        SEL_ZERO,
        SEL_MATCH,
        SEL_FREE,
        SEL_REL
    } t_slot_sel;

    typedef struct packed {
        logic      load_in;
        logic      scan_start;
        logic      scan_victim;
        logic      touch;
        logic      insert;
        logic      evict;
        logic      rel_dec;
        logic      fail_inc;
        logic      miss_inc;
        logic      res_we;
        t_slot_sel slot_sel;
        logic [2:0] status;
        logic      out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic       scan_busy;
        logic       found;
        logic       free_found;
        logic       victim_found;
        logic       over_budget;
        logic [1:0] kind;
        logic       load_ok;
        logic       rel_ok;
        logic       out_valid;
    } t_dp_sts;

endpackage

// File: rtl/bblru_datapath.sv
// directory datapath: slot memories, scan engine, counters and result register
module bblru_datapath import bblru_pkg::*; #(
    parameter int SLOTS    = SLOTS_DEF,
    parameter int PIN_BITS = PIN_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_sts     o_sts,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_file_id,
    input  logic [19:0] i_rate_key,
    input  logic [31:0] i_entry_bytes,
    input  logic        i_load_ok,
    input  logic [5:0]  i_release_slot,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic [2:0]  o_status,
    output logic [5:0]  o_slot_index,
    output logic [39:0] o_resident_total,
    output logic [6:0]  o_entry_total,
    output logic [31:0] o_failure_total,
    output logic [31:0] o_overrun_total
);

    localparam int IDXW  = $clog2(SLOTS);
    localparam int CNTW  = $clog2(SLOTS + 1);
    localparam int SUM_W = 33 + IDXW;
    localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};

    logic [KEY_W-1:0]    mem_key  [SLOTS];
    logic [31:0]         mem_size [SLOTS];
    logic [31:0]         mem_last [SLOTS];
    logic [PIN_BITS-1:0] mem_pins [SLOTS];

    logic [1:0]  r_in_kind;
    logic [31:0] r_in_file;
    logic [19:0] r_in_rate;
    logic [31:0] r_in_bytes;
    logic        r_in_ok;
    logic [5:0]  r_in_rslot;

    logic [31:0]     r_budget;
    logic [SLOTS-1:0] r_valid;
    logic [31:0]     r_use_clock;
    logic [SUM_W-1:0] r_sum;
    logic [CNTW-1:0] r_count;
    logic [31:0]     r_fail;
    logic [31:0]     r_miss;

    logic            r_scan_on;
    logic [IDXW-1:0] r_scan_cnt;
    logic            r_mode_victim;
    logic            r_pv;
    logic [IDXW-1:0] r_pidx;

    logic [KEY_W-1:0]    r_rd_key;
    logic [31:0]         r_rd_size;
    logic [31:0]         r_rd_last;
    logic [PIN_BITS-1:0] r_rd_pins;

    logic                r_found;
    logic [IDXW-1:0]     r_m_idx;
    logic [PIN_BITS-1:0] r_m_pins;
    logic                r_free_found;
    logic [IDXW-1:0]     r_free_idx;
    logic                r_v_found;
    logic [IDXW-1:0]     r_v_idx;
    logic [31:0]         r_v_last;
    logic [31:0]         r_v_size;

    logic [2:0]  r_res_status;
    logic [5:0]  r_res_slot;
    logic        r_out_valid;
    logic [2:0]  r_o_status;
    logic [5:0]  r_o_slot;
    logic [39:0] r_o_sum;
    logic [6:0]  r_o_count;
    logic [31:0] r_o_fail;
    logic [31:0] r_o_miss;

    logic [KEY_W-1:0] w_key;
    logic [IDXW-1:0]  w_rel_idx;
    logic             w_rel_in_range;
    logic [IDXW-1:0]  w_rd_addr;
    logic [31:0]      w_next_use;
    logic [5:0]       w_slot;

    assign w_key          = {r_in_file, r_in_rate};
    assign w_rel_idx      = IDXW'(r_in_rslot);
    assign w_rel_in_range = (32'(r_in_rslot) < 32'(SLOTS));
    assign w_rd_addr      = r_scan_on ? r_scan_cnt : w_rel_idx;
    assign w_next_use     = r_use_clock + 32'd1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in_kind  <= i_kind;
            r_in_file  <= i_file_id;
            r_in_rate  <= i_rate_key;
            r_in_bytes <= i_entry_bytes;
            r_in_ok    <= i_load_ok;
            r_in_rslot <= i_release_slot;
        end
    end

    // slot memories
    always_ff @(posedge i_clk) begin
        r_rd_key  <= mem_key[w_rd_addr];
        r_rd_size <= mem_size[w_rd_addr];
        r_rd_last <= mem_last[w_rd_addr];
        r_rd_pins <= mem_pins[w_rd_addr];
        if (i_cmd.insert) begin
            mem_key[r_free_idx]  <= w_key;
            mem_size[r_free_idx] <= r_in_bytes;
        end
        if (i_cmd.insert) begin
            mem_last[r_free_idx] <= w_next_use;
        end else if (i_cmd.touch) begin
            mem_last[r_m_idx] <= w_next_use;
        end
        if (i_cmd.insert) begin
            mem_pins[r_free_idx] <= PIN_BITS'(1);
        end else if (i_cmd.touch) begin
            mem_pins[r_m_idx] <= (r_m_pins == PIN_MAX) ? r_m_pins : r_m_pins + 1'b1;
        end else if (i_cmd.rel_dec) begin
            mem_pins[w_rel_idx] <= r_rd_pins - 1'b1;
        end
    end

    // scan engine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_on    <= 1'b0;
            r_pv         <= 1'b0;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
            r_v_found    <= 1'b0;
        end else begin
            r_pv <= r_scan_on;
            if (i_cmd.scan_start) begin
                r_scan_on     <= 1'b1;
                r_scan_cnt    <= '0;
                r_mode_victim <= i_cmd.scan_victim;
                r_found       <= 1'b0;
                r_free_found  <= 1'b0;
                r_v_found     <= 1'b0;
            end else if (r_scan_on) begin
                if (r_scan_cnt == IDXW'(SLOTS - 1)) begin
                    r_scan_on <= 1'b0;
                end
                r_scan_cnt <= r_scan_cnt + 1'b1;
            end
            if (r_pv) begin
                if (!r_mode_victim) begin
                    if (r_valid[r_pidx] && r_rd_key == w_key && !r_found) begin
                        r_found  <= 1'b1;
                        r_m_idx  <= r_pidx;
                        r_m_pins <= r_rd_pins;
                    end
                    if (!r_valid[r_pidx] && !r_free_found) begin
                        r_free_found <= 1'b1;
                        r_free_idx   <= r_pidx;
                    end
                end else if (r_valid[r_pidx] && r_rd_pins == '0 &&
                             (!r_v_found || r_rd_last < r_v_last)) begin
                    r_v_found <= 1'b1;
                    r_v_idx   <= r_pidx;
                    r_v_last  <= r_rd_last;
                    r_v_size  <= r_rd_size;
                end
            end
        end
        r_pidx <= r_scan_cnt;
    end

    // directory totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget    <= '1;
            r_valid     <= '0;
            r_use_clock <= '0;
            r_sum       <= '0;
            r_count     <= '0;
            r_fail      <= '0;
            r_miss      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_budget <= i_cfg_wdata;
            end
            if (i_cmd.touch || i_cmd.insert) begin
                r_use_clock <= w_next_use;
            end
            if (i_cmd.insert) begin
                r_valid[r_free_idx] <= 1'b1;
                r_sum   <= r_sum + SUM_W'(r_in_bytes);
                r_count <= r_count + 1'b1;
            end else if (i_cmd.evict) begin
                r_valid[r_v_idx] <= 1'b0;
                r_sum   <= r_sum - SUM_W'(r_v_size);
                r_count <= r_count - 1'b1;
            end
            if (i_cmd.fail_inc && r_fail != '1) begin
                r_fail <= r_fail + 32'd1;
            end
            if (i_cmd.miss_inc && r_miss != '1) begin
                r_miss <= r_miss + 32'd1;
            end
        end
    end

    always_comb begin
        case (i_cmd.slot_sel)
            SEL_MATCH: w_slot = 6'(r_m_idx);
            SEL_FREE:  w_slot = 6'(r_free_idx);
            SEL_REL:   w_slot = r_in_rslot;
            default:   w_slot = 6'd0;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.res_we) begin
            r_res_status <= i_cmd.status;
            r_res_slot   <= w_slot;
        end
        if (i_cmd.out_load) begin
            r_o_status <= r_res_status;
            r_o_slot   <= r_res_slot;
            r_o_sum    <= (64'(r_sum) > 64'hFF_FFFF_FFFF) ? '1 : 40'(r_sum);
            r_o_count  <= 7'(r_count);
            r_o_fail   <= r_fail;
            r_o_miss   <= r_miss;
        end
    end

    assign o_sts.scan_busy    = r_scan_on | r_pv;
    assign o_sts.found        = r_found;
    assign o_sts.free_found   = r_free_found;
    assign o_sts.victim_found = r_v_found;
    assign o_sts.over_budget  = r_sum > SUM_W'(r_budget);
    assign o_sts.kind         = r_in_kind;
    assign o_sts.load_ok      = r_in_ok;
    assign o_sts.rel_ok       = w_rel_in_range && r_valid[w_rel_idx] && (r_rd_pins != '0);
    assign o_sts.out_valid    = r_out_valid;

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_o_status;
    assign o_slot_index     = r_o_slot;
    assign o_resident_total = r_o_sum;
    assign o_entry_total    = r_o_count;
    assign o_failure_total  = r_o_fail;
    assign o_overrun_total  = r_o_miss;

endmodule

// File: rtl/bblru_ctrl.sv
// directory controller state machine
module bblru_ctrl import bblru_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_cfg_we,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_emit, n_emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_emit  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_emit  <= n_emit;
        end
    end

    always_comb begin
        n_state = r_state;
        n_emit  = r_emit;
        unique case (r_state)
            S_IDLE: begin
                if (i_cfg_we) begin
                    n_state = S_SW_CHK;
                    n_emit  = 1'b0;
                end else if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_emit = 1'b1;
                case (i_sts.kind)
                    KIND_RELEASE: n_state = S_REL1;
                    KIND_SWEEP:   n_state = S_SW_CHK;
                    default:      n_state = S_LOOK;
                endcase
            end
            S_LOOK: begin
                if (!i_sts.scan_busy) begin
                    if (!i_sts.found && i_sts.kind == KIND_ACQUIRE && i_sts.load_ok &&
                        i_sts.free_found) begin
                        n_state = S_SW_CHK;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_REL1: n_state = S_REL2;
            S_REL2: n_state = S_DONE;
            S_SW_CHK: begin
                if (i_sts.over_budget) begin
                    n_state = S_VSCAN;
                end else begin
                    n_state = r_emit ? S_DONE : S_IDLE;
                end
            end
            S_VSCAN: begin
                if (!i_sts.scan_busy) begin
                    if (i_sts.victim_found) begin
                        n_state = S_SW_CHK;
                    end else begin
                        n_state = r_emit ? S_DONE : S_IDLE;
                    end
                end
            end
            S_DONE: begin
                if (!i_sts.out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.slot_sel = SEL_ZERO;
        o_cmd.status   = ST_HIT;
        o_in_ready     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = !i_cfg_we;
                o_cmd.load_in = i_in_valid && !i_cfg_we;
            end
            S_DECODE: begin
                if (i_sts.kind == KIND_SWEEP) begin
                    o_cmd.res_we = 1'b1;
                end else if (i_sts.kind != KIND_RELEASE) begin
                    o_cmd.scan_start = 1'b1;
                end
            end
            S_LOOK: begin
                if (!i_sts.scan_busy) begin
                    o_cmd.res_we = 1'b1;
                    if (i_sts.found) begin
                        o_cmd.touch    = 1'b1;
                        o_cmd.slot_sel = SEL_MATCH;
                    end else if (i_sts.kind == KIND_PEEK) begin
                        o_cmd.status = ST_NOT_FOUND;
                    end else if (!i_sts.load_ok) begin
                        o_cmd.fail_inc = 1'b1;
                        o_cmd.status   = ST_LOAD_FAIL;
                    end else if (!i_sts.free_found) begin
                        o_cmd.status = ST_FULL;
                    end else begin
                        o_cmd.insert   = 1'b1;
                        o_cmd.status   = ST_INSERTED;
                        o_cmd.slot_sel = SEL_FREE;
                    end
                end
            end
            S_REL1: begin
            end
            S_REL2: begin
                o_cmd.res_we = 1'b1;
                if (i_sts.rel_ok) begin
                    o_cmd.rel_dec  = 1'b1;
                    o_cmd.slot_sel = SEL_REL;
                end else begin
                    o_cmd.status = ST_NOT_FOUND;
                end
            end
            S_SW_CHK: begin
                if (i_sts.over_budget) begin
                    o_cmd.scan_start  = 1'b1;
                    o_cmd.scan_victim = 1'b1;
                end
            end
            S_VSCAN: begin
                if (!i_sts.scan_busy) begin
                    if (i_sts.victim_found) begin
                        o_cmd.evict = 1'b1;
                    end else begin
                        o_cmd.miss_inc = 1'b1;
                    end
                end
            end
            S_DONE: begin
                o_cmd.out_load = !i_sts.out_valid || i_out_ready;
            end
            default: begin
            end
        endcase
    end

endmodule

// File: rtl/byte_budget_lru_cache_directory_top.sv
// top level of the byte budget lru cache directory
// a lookup scans all SLOTS entries, a release reads one slot, and each eviction round scans them all again
// throughput: one transaction at a time, set by the single-port slot scan over SLOTS entries
// a budget write while idle starts a sweep; no input transaction is taken until it ends
// reset (synchronous, active low) clears valid bits, totals and sets the budget to all ones
module byte_budget_lru_cache_directory_top import bblru_pkg::*; #(
    parameter int SLOTS    = SLOTS_DEF,
    parameter int PIN_BITS = PIN_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_file_id,
    input  logic [19:0] i_rate_key,
    input  logic [31:0] i_entry_bytes,
    input  logic        i_load_ok,
    input  logic [5:0]  i_release_slot,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [5:0]  o_slot_index,
    output logic [39:0] o_resident_total,
    output logic [6:0]  o_entry_total,
    output logic [31:0] o_failure_total,
    output logic [31:0] o_overrun_total
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    bblru_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cfg_we    (i_cfg_we),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    bblru_datapath #(
        .SLOTS    (SLOTS),
        .PIN_BITS (PIN_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_kind           (i_kind),
        .i_file_id        (i_file_id),
        .i_rate_key       (i_rate_key),
        .i_entry_bytes    (i_entry_bytes),
        .i_load_ok        (i_load_ok),
        .i_release_slot   (i_release_slot),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_status         (o_status),
        .o_slot_index     (o_slot_index),
        .o_resident_total (o_resident_total),
        .o_entry_total    (o_entry_total),
        .o_failure_total  (o_failure_total),
        .o_overrun_total  (o_overrun_total)
    );

endmodule
